[src/lpht_pkg.sv]
// Shared types, constants and helpers for the linear probe hash table.
// Used by the controller, datapath, top level and checker.
package lpht_pkg;

   localparam int SLOTS = 16;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam int RECIP = (1 << 16) / SLOTS;
   localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_REPLACE = 2'd1,
      OP_FIND    = 2'd2,
      OP_DELETE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_STORED  = 3'd0,
      ST_FULL    = 3'd1,
      ST_FOUND   = 3'd2,
      ST_MISSING = 3'd3,
      ST_DELETED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SRC_ZERO  = 2'd0,
      SRC_IDX   = 2'd1,
      SRC_HOME  = 2'd2,
      SRC_MATCH = 2'd3
   } slot_src_type;

   typedef enum logic [1:0] {
      WR_NONE     = 2'd0,
      WR_NEW_IDX  = 2'd1,
      WR_NEW_HOME = 2'd2,
      WR_OLD_IDX  = 2'd3
   } wr_sel_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'd0,
      S_START = 3'd1,
      S_PROBE = 3'd2,
      S_EVICT = 3'd3,
      S_SCAN  = 3'd4,
      S_DONE  = 3'd5
   } state_type;

   typedef struct packed {
      logic         req_ready;
      logic         init_probe;
      logic         init_probe_next;
      logic         step_probe;
      logic         init_scan;
      logic         scan;
      wr_sel_type   wr_sel;
      logic         clr_valid;
      logic         set_res;
      status_type   res_status;
      slot_src_type res_src;
      logic         load_rsp;
   } cmd_type;

   typedef struct packed {
      logic   req_fire;
      op_type op;
      logic   home_valid;
      logic   probe_done;
      logic   probe_free;
      logic   foreign;
      logic   cmp_hit;
      logic   cmp_last;
      logic   out_free;
   } stat_type;

   // first byte modulo SLOTS: reciprocal multiply, one correction step
   function automatic logic [IDX_W-1:0] home_of(input logic [7:0] b);
      logic [24:0] prod;
      logic [8:0]  quot;
      logic [17:0] rem;
      prod = 25'(b) * 25'(RECIP);
      quot = prod[24:16];
      rem  = 18'(b) - 18'(18'(quot) * 18'(SLOTS));
      if (rem >= 18'(SLOTS)) begin
         rem = rem - 18'(SLOTS);
      end
      if (IS_POW2) begin
         return b[IDX_W-1:0];
      end
      return rem[IDX_W-1:0];
   endfunction

   function automatic logic [3:0] slot_out(input logic [IDX_W-1:0] s);
      logic [IDX_W+3:0] t;
      t = (IDX_W + 4)'(s);
      return t[3:0];
   endfunction

endpackage

[src/lpht_if.sv]
// Request and response channel interfaces for the linear probe hash table.
// Depends on nothing; payload widths are fixed by the item formats.
interface lpht_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [63:0] key_word;
   logic [63:0] meaning_value;
   modport source (output valid, req_type, key_word, meaning_value, input ready);
   modport sink (input valid, req_type, key_word, meaning_value, output ready);
endinterface

interface lpht_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [3:0] slot_index;
   modport source (output valid, status, slot_index, input ready);
   modport sink (input valid, status, slot_index, output ready);
endinterface

[src/lpht_ctrl.sv]
// Controller state machine for the linear probe hash table.
// Drives lpht_pkg::cmd_type commands from lpht_pkg::stat_type status.
module lpht_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  lpht_pkg::stat_type stat,
   output lpht_pkg::cmd_type  cmd
);

   lpht_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpht_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpht_pkg::S_IDLE: begin
            if (stat.req_fire) state_in = lpht_pkg::S_START;
         end
         lpht_pkg::S_START: begin
            unique case (stat.op)
               lpht_pkg::OP_INSERT: state_in = lpht_pkg::S_PROBE;
               lpht_pkg::OP_REPLACE: begin
                  state_in = stat.home_valid ? lpht_pkg::S_PROBE : lpht_pkg::S_DONE;
               end
               lpht_pkg::OP_FIND, lpht_pkg::OP_DELETE: state_in = lpht_pkg::S_SCAN;
               default: state_in = lpht_pkg::S_IDLE;
            endcase
         end
         lpht_pkg::S_PROBE: begin
            if (stat.probe_done) begin
               state_in = lpht_pkg::S_DONE;
            end else if (stat.probe_free) begin
               if (stat.op == lpht_pkg::OP_REPLACE && stat.foreign) begin
                  state_in = lpht_pkg::S_EVICT;
               end else begin
                  state_in = lpht_pkg::S_DONE;
               end
            end
         end
         lpht_pkg::S_EVICT: state_in = lpht_pkg::S_DONE;
         lpht_pkg::S_SCAN: begin
            if (stat.cmp_hit || stat.cmp_last) state_in = lpht_pkg::S_DONE;
         end
         lpht_pkg::S_DONE: begin
            if (stat.out_free) state_in = lpht_pkg::S_IDLE;
         end
         default: state_in = lpht_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         lpht_pkg::S_IDLE: cmd.req_ready = 1'b1;
         lpht_pkg::S_START: begin
            unique case (stat.op)
               lpht_pkg::OP_INSERT: cmd.init_probe = 1'b1;
               lpht_pkg::OP_REPLACE: begin
                  if (stat.home_valid) begin
                     cmd.init_probe_next = 1'b1;
                  end else begin
                     cmd.wr_sel     = lpht_pkg::WR_NEW_HOME;
                     cmd.set_res    = 1'b1;
                     cmd.res_status = lpht_pkg::ST_STORED;
                     cmd.res_src    = lpht_pkg::SRC_HOME;
                  end
               end
               lpht_pkg::OP_FIND, lpht_pkg::OP_DELETE: cmd.init_scan = 1'b1;
               default: cmd.init_scan = 1'b0;
            endcase
         end
         lpht_pkg::S_PROBE: begin
            priority if (stat.probe_done) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = lpht_pkg::ST_FULL;
               cmd.res_src    = lpht_pkg::SRC_ZERO;
            end else if (stat.probe_free) begin
               if (stat.op == lpht_pkg::OP_REPLACE && stat.foreign) begin
                  cmd.wr_sel = lpht_pkg::WR_OLD_IDX;
               end else begin
                  cmd.wr_sel     = lpht_pkg::WR_NEW_IDX;
                  cmd.set_res    = 1'b1;
                  cmd.res_status = lpht_pkg::ST_STORED;
                  cmd.res_src    = lpht_pkg::SRC_IDX;
               end
            end else begin
               cmd.step_probe = 1'b1;
            end
         end
         lpht_pkg::S_EVICT: begin
            cmd.wr_sel     = lpht_pkg::WR_NEW_HOME;
            cmd.set_res    = 1'b1;
            cmd.res_status = lpht_pkg::ST_STORED;
            cmd.res_src    = lpht_pkg::SRC_HOME;
         end
         lpht_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.cmp_hit) begin
               cmd.set_res = 1'b1;
               cmd.res_src = lpht_pkg::SRC_MATCH;
               if (stat.op == lpht_pkg::OP_DELETE) begin
                  cmd.clr_valid  = 1'b1;
                  cmd.res_status = lpht_pkg::ST_DELETED;
               end else begin
                  cmd.res_status = lpht_pkg::ST_FOUND;
               end
            end else if (stat.cmp_last) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = lpht_pkg::ST_MISSING;
               cmd.res_src    = lpht_pkg::SRC_ZERO;
            end
         end
         lpht_pkg::S_DONE: cmd.load_rsp = stat.out_free;
         default: cmd.req_ready = 1'b0;
      endcase
   end

endmodule

[src/lpht_dp.sv]
// Datapath for the linear probe hash table: request latch, valid flags,
// slot memory, probe and scan counters, result and response registers.
// Depends on lpht_pkg and the channel interfaces.
module lpht_dp (
   input  logic              clock,
   input  logic              reset,
   lpht_req_if.sink          req,
   lpht_rsp_if.source        rsp,
   input  lpht_pkg::cmd_type cmd,
   output lpht_pkg::stat_type stat
);

   lpht_pkg::op_type                op_ff;
   logic [63:0]                     key_ff;
   logic [63:0]                     mean_ff;
   logic [lpht_pkg::IDX_W-1:0]      home_ff;
   logic [lpht_pkg::IDX_W-1:0]      idx_ff;
   logic [lpht_pkg::CNT_W-1:0]      cnt_ff;
   logic                            cmp_vld_ff;
   logic [lpht_pkg::IDX_W-1:0]      cmp_idx_ff;
   logic [lpht_pkg::SLOTS-1:0]      valid_ff;
   logic [63:0]                     mem_word [lpht_pkg::SLOTS];
   logic [63:0]                     mem_mean [lpht_pkg::SLOTS];
   logic [63:0]                     rd_word_ff;
   logic [63:0]                     rd_mean_ff;
   lpht_pkg::status_type            res_status_ff;
   logic [lpht_pkg::IDX_W-1:0]      res_slot_ff;
   logic                            rsp_valid_ff;
   lpht_pkg::status_type            rsp_status_ff;
   logic [3:0]                      rsp_slot_ff;

   logic                            req_fire;
   logic                            wr_en;
   logic [lpht_pkg::IDX_W-1:0]      wr_addr;
   logic [63:0]                     wr_word;
   logic [63:0]                     wr_mean;
   logic [lpht_pkg::IDX_W-1:0]      rd_addr;
   logic [lpht_pkg::IDX_W-1:0]      res_slot_in;

   function automatic logic [lpht_pkg::IDX_W-1:0] wrap_next(
      input logic [lpht_pkg::IDX_W-1:0] i
   );
      if (i == lpht_pkg::IDX_W'(lpht_pkg::SLOTS - 1)) begin
         return '0;
      end
      return i + 1'b1;
   endfunction

   assign req.ready = cmd.req_ready;
   assign req_fire  = req.valid && cmd.req_ready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= lpht_pkg::op_type'(req.req_type);
         key_ff  <= req.key_word;
         mean_ff <= req.meaning_value;
         home_ff <= lpht_pkg::home_of(req.key_word[7:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_probe) begin
         idx_ff <= home_ff;
         cnt_ff <= '0;
      end else if (cmd.init_probe_next) begin
         idx_ff <= wrap_next(home_ff);
         cnt_ff <= lpht_pkg::CNT_W'(1);
      end else if (cmd.step_probe) begin
         idx_ff <= wrap_next(idx_ff);
         cnt_ff <= cnt_ff + 1'b1;
      end else if (cmd.init_scan) begin
         cnt_ff <= '0;
      end else if (cmd.scan && cnt_ff != lpht_pkg::CNT_W'(lpht_pkg::SLOTS)) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan && (cnt_ff != lpht_pkg::CNT_W'(lpht_pkg::SLOTS));
      end
      cmp_idx_ff <= cnt_ff[lpht_pkg::IDX_W-1:0];
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = idx_ff;
      wr_word = key_ff;
      wr_mean = mean_ff;
      unique case (cmd.wr_sel)
         lpht_pkg::WR_NONE:     wr_en = 1'b0;
         lpht_pkg::WR_NEW_IDX:  wr_addr = idx_ff;
         lpht_pkg::WR_NEW_HOME: wr_addr = home_ff;
         lpht_pkg::WR_OLD_IDX: begin
            wr_word = rd_word_ff;
            wr_mean = rd_mean_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   assign rd_addr = cmd.scan ? cnt_ff[lpht_pkg::IDX_W-1:0] : home_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_word[wr_addr] <= wr_word;
         mem_mean[wr_addr] <= wr_mean;
      end
      rd_word_ff <= mem_word[rd_addr];
      rd_mean_ff <= mem_mean[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (wr_en) valid_ff[wr_addr] <= 1'b1;
         if (cmd.clr_valid) valid_ff[cmp_idx_ff] <= 1'b0;
      end
   end

   always_comb begin
      unique case (cmd.res_src)
         lpht_pkg::SRC_ZERO:  res_slot_in = '0;
         lpht_pkg::SRC_IDX:   res_slot_in = idx_ff;
         lpht_pkg::SRC_HOME:  res_slot_in = home_ff;
         lpht_pkg::SRC_MATCH: res_slot_in = cmp_idx_ff;
         default:             res_slot_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_status;
         res_slot_ff   <= res_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= lpht_pkg::slot_out(res_slot_ff);
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.slot_index = rsp_slot_ff;

   always_comb begin
      stat.req_fire   = req_fire;
      stat.op         = op_ff;
      stat.home_valid = valid_ff[home_ff];
      stat.probe_done = (cnt_ff == lpht_pkg::CNT_W'(lpht_pkg::SLOTS));
      stat.probe_free = !valid_ff[idx_ff];
      stat.foreign    = (lpht_pkg::home_of(rd_word_ff[7:0]) != home_ff);
      stat.cmp_hit    = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_word_ff == key_ff);
      stat.cmp_last   = cmp_vld_ff &&
                        (cmp_idx_ff == lpht_pkg::IDX_W'(lpht_pkg::SLOTS - 1));
      stat.out_free   = !rsp_valid_ff || rsp.ready;
   end

endmodule

[src/linear_probe_hash_table.sv]
// Linear probe hash table: open-addressed table of lpht_pkg::SLOTS entries
// (16), each a valid flag, a 64-bit packed word and a 64-bit meaning, home slot
// = first byte modulo SLOTS. One request beat gives one response beat. Items
// are handled one at a time; the block takes a new request once the previous
// result has been loaded into the response register. Inserts walk the valid
// flags one slot per cycle from home (replace also reads the home entry to
// decide eviction). Find and delete stream the slots in order through the
// single memory read port, one per cycle, stopping at the first match. Valid
// flags clear at reset; no clearing pass is needed.
module linear_probe_hash_table (
   input  logic        clock,
   input  logic        reset,
   lpht_req_if.sink    req_bus,
   lpht_rsp_if.source  rsp_bus
);

   lpht_pkg::cmd_type  cmd;
   lpht_pkg::stat_type stat;

   lpht_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   lpht_dp u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule

[src/lpht_checker.sv]
// Port-level checks for the linear probe hash table, bound to the top level.
// Depends on lpht_pkg for status codes.
module lpht_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [3:0] rsp_slot_index
);

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_slot_index))
      else $error("response beat dropped or changed while stalled");

   a_no_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !$rose(rsp_valid))
      else $error("response appeared one cycle after request beat");

   a_zero_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == lpht_pkg::ST_FULL || rsp_status == lpht_pkg::ST_MISSING)
      |-> rsp_slot_index == 4'd0)
      else $error("nonzero slot on full or not-found response");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= lpht_pkg::ST_DELETED)
      else $error("response status out of range");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_slot_index (rsp_bus.slot_index)
);

[tb/linear_probe_hash_table_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for linear_probe_hash_table: directed and random table
// operations, checked beat by beat against an in-bench table predictor.
// Depends on lpht_pkg, the lpht_req_if / lpht_rsp_if interfaces and the RTL.
module linear_probe_hash_table_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_REQS = 430;
   localparam int POOL_MAX = 48;

   typedef struct {
      lpht_pkg::op_type op;
      logic [63:0]      key;
      logic [63:0]      meaning;
   } table_req_type;

   typedef struct {
      lpht_pkg::status_type status;
      logic [3:0]           slot;
   } table_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lpht_req_if req_bus();
   lpht_rsp_if rsp_bus();

   linear_probe_hash_table u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   table_req_type   pending_reqs[$];
   table_reply_type expected_replies[$];
   logic [63:0]     word_pool[$];

   logic            table_valid[lpht_pkg::SLOTS];
   logic [63:0]     table_word[lpht_pkg::SLOTS];
   logic [63:0]     table_meaning[lpht_pkg::SLOTS];

   int              total_reqs = 0;
   int              items_sent = 0;
   int              results_seen = 0;
   int              hold_left = 0;
   bit              hold_done = 1'b0;
   int              errors = 0;
   int              cycle_count = 0;
   table_req_type   next_req;
   table_reply_type want;

   function automatic int home_slot(logic [63:0] key);
      return int'(key[7:0]) % lpht_pkg::SLOTS;
   endfunction

   function automatic void write_entry(int idx, logic [63:0] key, logic [63:0] mean);
      table_valid[idx] = 1'b1;
      table_word[idx] = key;
      table_meaning[idx] = mean;
   endfunction

   function automatic table_reply_type apply_table_op(table_req_type r);
      table_reply_type rep;
      int home;
      int idx;
      int n;
      home = home_slot(r.key);
      rep.status = lpht_pkg::ST_FULL;
      rep.slot = '0;
      idx = -1;
      case (r.op)
         lpht_pkg::OP_INSERT: begin
            for (n = 0; n < lpht_pkg::SLOTS; n++) begin
               if (idx < 0 && !table_valid[(home + n) % lpht_pkg::SLOTS]) begin
                  idx = (home + n) % lpht_pkg::SLOTS;
               end
            end
            if (idx >= 0) begin
               write_entry(idx, r.key, r.meaning);
               rep.status = lpht_pkg::ST_STORED;
               rep.slot = 4'(idx);
            end
         end
         lpht_pkg::OP_REPLACE: begin
            if (!table_valid[home]) begin
               write_entry(home, r.key, r.meaning);
               rep.status = lpht_pkg::ST_STORED;
               rep.slot = 4'(home);
            end else begin
               for (n = 1; n < lpht_pkg::SLOTS; n++) begin
                  if (idx < 0 && !table_valid[(home + n) % lpht_pkg::SLOTS]) begin
                     idx = (home + n) % lpht_pkg::SLOTS;
                  end
               end
               if (idx >= 0) begin
                  if (home_slot(table_word[home]) != home) begin
                     write_entry(idx, table_word[home], table_meaning[home]);
                     write_entry(home, r.key, r.meaning);
                     rep.slot = 4'(home);
                  end else begin
                     write_entry(idx, r.key, r.meaning);
                     rep.slot = 4'(idx);
                  end
                  rep.status = lpht_pkg::ST_STORED;
               end
            end
         end
         default: begin
            for (n = 0; n < lpht_pkg::SLOTS; n++) begin
               if (idx < 0 && table_valid[n] && table_word[n] == r.key) idx = n;
            end
            if (idx >= 0) begin
               if (r.op == lpht_pkg::OP_DELETE) begin
                  table_valid[idx] = 1'b0;
                  rep.status = lpht_pkg::ST_DELETED;
               end else begin
                  rep.status = lpht_pkg::ST_FOUND;
               end
               rep.slot = 4'(idx);
            end else begin
               rep.status = lpht_pkg::ST_MISSING;
            end
         end
      endcase
      return rep;
   endfunction

   task automatic queue_req(lpht_pkg::op_type op, logic [63:0] key, logic [63:0] mean);
      table_req_type r;
      r.op = op;
      r.key = key;
      r.meaning = mean;
      pending_reqs.push_back(r);
      if (op == lpht_pkg::OP_INSERT || op == lpht_pkg::OP_REPLACE) word_pool.push_back(key);
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_replies.push_back(apply_table_op(next_req));
            items_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_reqs.size() > 0 &&
                !((items_sent < 150 || items_sent >= 230) && $urandom_range(0, 99) < 37)) begin
               next_req = pending_reqs.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.req_type <= next_req.op;
               req_bus.key_word <= next_req.key;
               req_bus.meaning_value <= next_req.meaning;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // hold off the response side for a long stretch once
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && results_seen >= 320) begin
            hold_left <= 200;
            hold_done <= 1'b1;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got status %0d slot %0d",
                        $time, rsp_bus.status, rsp_bus.slot_index);
               errors++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_bus.status);
                  errors++;
               end
               if (rsp_bus.slot_index !== want.slot) begin
                  $display("%0t: slot_index mismatch, expected %0d, got %0d",
                           $time, want.slot, rsp_bus.slot_index);
                  errors++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !((results_seen < 150 || results_seen >= 230) &&
                               $urandom_range(0, 99) < 37);
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int n;
      int pick;
      lpht_pkg::op_type op;
      logic [63:0] key;
      logic [63:0] mean;
      req_bus.valid = 1'b0;
      req_bus.req_type = lpht_pkg::OP_INSERT;
      req_bus.key_word = '0;
      req_bus.meaning_value = '0;
      rsp_bus.ready = 1'b0;
      for (n = 0; n < lpht_pkg::SLOTS; n++) begin
         table_valid[n] = 1'b0;
         table_word[n] = '0;
         table_meaning[n] = '0;
      end

      // empty table, then collisions, wraparound, eviction and duplicates
      queue_req(lpht_pkg::OP_FIND, 64'h0, 64'h0);
      queue_req(lpht_pkg::OP_DELETE, 64'h0, '1);
      queue_req(lpht_pkg::OP_INSERT, 64'h0, 64'h0);
      queue_req(lpht_pkg::OP_INSERT, '1, '1);
      queue_req(lpht_pkg::OP_INSERT, {rand_word()} & ~64'hFF | 64'h1F, rand_word());
      queue_req(lpht_pkg::OP_REPLACE, {rand_word()} & ~64'hFF | 64'h01, rand_word());
      queue_req(lpht_pkg::OP_REPLACE, {rand_word()} & ~64'hFF | 64'h11, rand_word());
      queue_req(lpht_pkg::OP_INSERT, 64'h0, rand_word());
      queue_req(lpht_pkg::OP_FIND, 64'h0, rand_word());
      queue_req(lpht_pkg::OP_DELETE, 64'h0, rand_word());
      queue_req(lpht_pkg::OP_FIND, 64'h0, rand_word());
      // fill up, then hit the full table both ways
      for (n = 0; n < 11; n++) queue_req(lpht_pkg::OP_INSERT, rand_word(), rand_word());
      queue_req(lpht_pkg::OP_INSERT, rand_word(), rand_word());
      queue_req(lpht_pkg::OP_REPLACE, rand_word(), rand_word());

      for (n = 0; n < RANDOM_REQS; n++) begin
         op = lpht_pkg::op_type'($urandom_range(0, 3));
         if (word_pool.size() > 0 && $urandom_range(0, 99) < 75) begin
            key = word_pool[$urandom_range(0, word_pool.size() - 1)];
         end else begin
            key = rand_word();
         end
         pick = $urandom_range(0, 15);
         mean = (pick == 0) ? 64'h0 : (pick == 1) ? '1 : rand_word();
         queue_req(op, key, mean);
         if (word_pool.size() > POOL_MAX) word_pool.delete($urandom_range(0, POOL_MAX));
      end
      total_reqs = pending_reqs.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait (items_sent == total_reqs);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
src/lpht_pkg.sv
src/lpht_if.sv
src/lpht_ctrl.sv
src/lpht_dp.sv
src/linear_probe_hash_table.sv
src/lpht_checker.sv
tb/linear_probe_hash_table_tb.sv
